// ----- design/iwg_pkg.sv -----
package iwg_pkg;

    // Default run shape: template words, then idle words.
    localparam int DEF_TEMPLATE_LEN = 27;
    localparam int DEF_IDLE_WORDS   = 8;

    // Stored template words per waveform, and the index width that covers the default run.
    localparam int ROM_LEN   = 27;
    localparam int ROM_IDX_W = 6;
    localparam int SEL_W     = 2;
    localparam int WORD_W    = 16;

    // Bit positions inside a drive word.
    localparam int BIT_D1    = 0;
    localparam int BIT_D2    = 1;
    localparam int BIT_D3    = 2;
    localparam int BIT_CSYNC = 3;
    localparam int BIT_F3    = 10;
    localparam int BIT_F5    = 11;
    localparam int BIT_LAST  = 14;
    localparam int BIT_NORM  = 15;

    // Waveform codes.
    localparam logic [SEL_W-1:0] WAVE_COLOR_A = 2'd0;
    localparam logic [SEL_W-1:0] WAVE_COLOR_B = 2'd1;
    localparam logic [SEL_W-1:0] WAVE_BLACK_A = 2'd2;
    localparam logic [SEL_W-1:0] WAVE_BLACK_B = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pkt;        // latch a new packet and restart the pointer
        logic emit;            // compute one word into the output register
        logic template_phase;  // word comes from the template, not an idle word
        logic last_word;       // final word of the run
    } iwg_cmd_t;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t ROM_COLOR_A [ROM_LEN] = '{
        16'h0000, 16'hc001, 16'hc101, 16'hc142, 16'h0042, 16'h4001, 16'h4101, 16'h4112,
        16'h0012, 16'h4001, 16'h4101, 16'h4302, 16'h0602, 16'h4401, 16'h4501, 16'h4522,
        16'h0422, 16'h0402, 16'h4000, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
        16'h0800, 16'h0800, 16'h0800};
    localparam word_t ROM_COLOR_B [ROM_LEN] = '{
        16'h0000, 16'hc000, 16'hc101, 16'hc141, 16'h0042, 16'h0002, 16'h4101, 16'h4111,
        16'h0012, 16'h4002, 16'h4101, 16'h4301, 16'h0602, 16'h4402, 16'h4501, 16'h4521,
        16'h0422, 16'h0402, 16'h4000, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
        16'h0800, 16'h0800, 16'h0800};
    localparam word_t ROM_BLACK_A [ROM_LEN] = '{
        16'h0000, 16'hc001, 16'hc101, 16'hc142, 16'h0042, 16'hc001, 16'hc101, 16'hc112,
        16'h0012, 16'h4001, 16'h4101, 16'h4302, 16'h0602, 16'h0401, 16'h0501, 16'h0522,
        16'h0422, 16'h0402, 16'h4000, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
        16'h0800, 16'h0800, 16'h0800};
    localparam word_t ROM_BLACK_B [ROM_LEN] = '{
        16'h0000, 16'hc000, 16'hc101, 16'hc141, 16'h0042, 16'h0002, 16'hc101, 16'hc111,
        16'h0012, 16'h4002, 16'h4101, 16'h4301, 16'h0602, 16'h0402, 16'h0501, 16'h0521,
        16'h0422, 16'h0402, 16'h4002, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
        16'h0800, 16'h0800, 16'h0800};

    // Template lookup; positions past the stored words read as zero.
    function automatic word_t rom_word(input logic [SEL_W-1:0] sel,
                                       input logic [ROM_IDX_W-1:0] idx);
        word_t w;
        w = '0;
        if (idx < ROM_IDX_W'(ROM_LEN)) begin
            case (sel)
                WAVE_COLOR_A: w = ROM_COLOR_A[idx[4:0]];
                WAVE_COLOR_B: w = ROM_COLOR_B[idx[4:0]];
                WAVE_BLACK_A: w = ROM_BLACK_A[idx[4:0]];
                WAVE_BLACK_B: w = ROM_BLACK_B[idx[4:0]];
                default:      w = '0;
            endcase
        end
        return w;
    endfunction

endpackage

// ----- design/iwg_ctrl.sv -----
module iwg_ctrl #(
    parameter int TEMPLATE_LEN = iwg_pkg::DEF_TEMPLATE_LEN,
    parameter int IDLE_WORDS   = iwg_pkg::DEF_IDLE_WORDS,
    parameter int CNT_W        = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output iwg_pkg::iwg_cmd_t cmd,
    output logic [CNT_W-1:0]  word_idx
);
    import iwg_pkg::*;

    localparam int TOTAL = TEMPLATE_LEN + IDLE_WORDS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic             advance;
    logic             is_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign word_idx = cnt_reg;

    // During a run, a word is produced whenever the output register is free or draining.
    assign advance = (state_reg == ST_RUN) && (!valid_reg || m_tready);
    assign is_last = (cnt_reg == CNT_W'(TOTAL - 1));

    assign cmd.load_pkt       = s_tvalid && s_tready;
    assign cmd.emit           = advance;
    assign cmd.template_phase = ({1'b0, cnt_reg} < (CNT_W + 1)'(TEMPLATE_LEN));
    assign cmd.last_word      = is_last;

    // Sequencer: wait for a packet, then step through the run one word at a time.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    valid_next = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- design/iwg_datapath.sv -----
module iwg_datapath #(
    parameter int CNT_W = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [iwg_pkg::SEL_W-1:0]     cfg_wr_data,
    input  logic [23:0]                   s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tuser,
    input  iwg_pkg::iwg_cmd_t             cmd,
    input  logic [CNT_W-1:0]              word_idx,
    output logic [iwg_pkg::WORD_W-1:0]    m_tdata,
    output logic                          m_tlast
);
    import iwg_pkg::*;

    logic [SEL_W-1:0] wave_sel_reg;
    logic [7:0]       d1_reg, d2_reg, d3_reg;
    logic             last_pkt_reg, empty_reg;
    logic [7:0]       ptr_reg, ptr_next;
    logic [1:0]       prev_reg, prev_next;
    word_t            word_reg, word_next;
    logic             tlast_reg;

    word_t            tmpl;
    logic [7:0]       act;
    logic [1:0]       tgl;

    // Waveform select register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_sel_reg <= WAVE_COLOR_A;
        end else if (cfg_wr_en) begin
            wave_sel_reg <= cfg_wr_data;
        end
    end

    // Packet latch.
    always_ff @(posedge aclk) begin
        if (cmd.load_pkt) begin
            d1_reg       <= s_tdata[7:0];
            d2_reg       <= s_tdata[15:8];
            d3_reg       <= s_tdata[23:16];
            last_pkt_reg <= s_tlast;
            empty_reg    <= s_tuser;
        end
    end

    assign tmpl = rom_word(wave_sel_reg, ROM_IDX_W'(word_idx));
    assign act  = d1_reg | d2_reg | d3_reg;
    assign tgl  = tmpl[1:0];

    // Word build: step the bit pointer on a toggle change, gate power, insert data.
    always_comb begin
        ptr_next  = ptr_reg;
        prev_next = prev_reg;
        word_next = '0;
        if (cmd.template_phase && !empty_reg) begin
            if (tgl != prev_reg) begin
                ptr_next  = (ptr_reg == 8'd0) ? 8'd1 : {ptr_reg[6:0], 1'b0};
                prev_next = tgl;
            end
            word_next         = tmpl;
            word_next[3:0]    = 4'd0;
            word_next[BIT_F3] = tmpl[BIT_F3] && (act[3:0] != 4'd0);
            word_next[BIT_F5] = tmpl[BIT_F5] && (act[7:4] != 4'd0);
            if (tgl != 2'd0) begin
                word_next[BIT_D1] = ((d1_reg & ptr_next) == 8'd0);
                word_next[BIT_D2] = ((d2_reg & ptr_next) == 8'd0);
                word_next[BIT_D3] = ((d3_reg & ptr_next) == 8'd0);
            end
            word_next[BIT_CSYNC] = last_pkt_reg ? tmpl[BIT_LAST] : tmpl[BIT_NORM];
        end
    end

    // Pointer state restarts for every packet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            prev_reg <= '0;
        end else if (cmd.load_pkt) begin
            ptr_reg  <= '0;
            prev_reg <= '0;
        end else if (cmd.emit) begin
            ptr_reg  <= ptr_next;
            prev_reg <= prev_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            word_reg  <= word_next;
            tlast_reg <= cmd.last_word;
        end
    end

    assign m_tdata = word_reg;
    assign m_tlast = tlast_reg;

endmodule

// ----- design/inkjet_packet_waveform_gen_top.sv -----
// Channel   Ports                    Contents (lowest bit first)
// ------    ---------------------    -------------------------------------------------
// input     s_tvalid/s_tready        tdata: d1_bits, d2_bits, d3_bits; tlast: last_packet;
//                                    tuser: line_empty
// output    m_tvalid/m_tready        tdata: drive_word; tlast: last_of_run
// config    cfg_wr_en/cfg_wr_data    waveform_select
//
// One packet yields TEMPLATE_LEN + IDLE_WORDS drive words (35 by default): the beat is
// taken first, then one drive word per cycle follows from the sequencer's word counter.
// Packets are handled one at a time; the next one is taken while the final word
// still waits in the output register. Output stalls hold the sequencer in place.
// Reset is synchronous and active low; waveform_select returns to color a.
module inkjet_packet_waveform_gen_top #(
    parameter int TEMPLATE_LEN = iwg_pkg::DEF_TEMPLATE_LEN,
    parameter int IDLE_WORDS   = iwg_pkg::DEF_IDLE_WORDS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [iwg_pkg::SEL_W-1:0]  cfg_wr_data,   // waveform_select
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,       // d1_bits, d2_bits, d3_bits
    input  logic                       s_tlast,       // last_packet
    input  logic                       s_tuser,       // line_empty
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [iwg_pkg::WORD_W-1:0] m_tdata,       // drive_word
    output logic                       m_tlast        // last_of_run
);
    import iwg_pkg::*;

    localparam int TOTAL = TEMPLATE_LEN + IDLE_WORDS;
    localparam int CNT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    iwg_cmd_t         cmd;
    logic [CNT_W-1:0] word_idx;

    iwg_ctrl #(
        .TEMPLATE_LEN (TEMPLATE_LEN),
        .IDLE_WORDS   (IDLE_WORDS),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .word_idx (word_idx)
    );

    iwg_datapath #(
        .CNT_W (CNT_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .word_idx    (word_idx),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Only one packet is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input beat taken while a packet was in work");

    // A new output word only appears while a run is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output word produced outside a run");

    // When IDLE_WORDS > 0, the closing word of a run is an idle word and therefore zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((IDLE_WORDS > 0) && m_tvalid && m_tlast) |-> (m_tdata == '0))
        else $error("final idle word is not zero");

endmodule

// ----- tb/drive_word_checker.sv -----
module drive_word_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [iwg_pkg::SEL_W-1:0]  cfg_wr_data,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [23:0]                s_tdata,
    input  logic                       s_tlast,
    input  logic                       s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [iwg_pkg::WORD_W-1:0] m_tdata,
    input  logic                       m_tlast,
    output int                         fail_count,
    output int                         words_pending,
    output int                         words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import iwg_pkg::*;

    localparam int TEMPLATE_WORDS = DEF_TEMPLATE_LEN;
    localparam int IDLE_COUNT     = DEF_IDLE_WORDS;
    localparam int RUN_WORDS      = TEMPLATE_WORDS + IDLE_COUNT;
    localparam int STORED_WORDS   = 27;
    localparam int MAX_REPORTS    = 25;

    // Template table kept here independently of the design, one row per waveform.
    localparam logic [15:0] WAVE_TABLE [4][STORED_WORDS] = '{
        '{16'h0000, 16'hc001, 16'hc101, 16'hc142, 16'h0042, 16'h4001, 16'h4101, 16'h4112,
          16'h0012, 16'h4001, 16'h4101, 16'h4302, 16'h0602, 16'h4401, 16'h4501, 16'h4522,
          16'h0422, 16'h0402, 16'h4000, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
          16'h0800, 16'h0800, 16'h0800},
        '{16'h0000, 16'hc000, 16'hc101, 16'hc141, 16'h0042, 16'h0002, 16'h4101, 16'h4111,
          16'h0012, 16'h4002, 16'h4101, 16'h4301, 16'h0602, 16'h4402, 16'h4501, 16'h4521,
          16'h0422, 16'h0402, 16'h4000, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
          16'h0800, 16'h0800, 16'h0800},
        '{16'h0000, 16'hc001, 16'hc101, 16'hc142, 16'h0042, 16'hc001, 16'hc101, 16'hc112,
          16'h0012, 16'h4001, 16'h4101, 16'h4302, 16'h0602, 16'h0401, 16'h0501, 16'h0522,
          16'h0422, 16'h0402, 16'h4000, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
          16'h0800, 16'h0800, 16'h0800},
        '{16'h0000, 16'hc000, 16'hc101, 16'hc141, 16'h0042, 16'h0002, 16'hc101, 16'hc111,
          16'h0012, 16'h4002, 16'h4101, 16'h4301, 16'h0602, 16'h0402, 16'h0501, 16'h0521,
          16'h0422, 16'h0402, 16'h4002, 16'h4000, 16'h4080, 16'h0880, 16'h0800, 16'h0800,
          16'h0800, 16'h0800, 16'h0800}};

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last_of_run;
    } drive_beat_t;

    drive_beat_t            drive_q [$];
    logic [SEL_W-1:0]       wave_sel = WAVE_COLOR_A;
    int                     n_fail = 0;
    int                     n_pending = 0;
    int                     n_checked = 0;

    assign fail_count    = n_fail;
    assign words_pending = n_pending;
    assign words_checked = n_checked;

    // Expand one packet into the full run of drive words it should produce.
    function automatic void expand_packet(input logic [7:0] d1, input logic [7:0] d2,
                                          input logic [7:0] d3, input logic last_pkt,
                                          input logic blank);
        logic [7:0]  act;
        logic [7:0]  ptr;
        logic [1:0]  tgl;
        logic [1:0]  prev_tgl;
        logic [15:0] keep;
        logic [15:0] csync_src;
        logic [15:0] tmpl;
        logic [15:0] w;
        drive_beat_t beat;

        act  = d1 | d2 | d3;
        keep = 16'hfff0;
        if (act[3:0] == 4'h0) begin
            keep[BIT_F3] = 1'b0;
        end
        if (act[7:4] == 4'h0) begin
            keep[BIT_F5] = 1'b0;
        end
        csync_src = last_pkt ? (16'h1 << BIT_LAST) : (16'h1 << BIT_NORM);
        ptr       = 8'h00;
        prev_tgl  = 2'b00;

        for (int i = 0; i < TEMPLATE_WORDS; i++) begin
            tmpl = (i < STORED_WORDS) ? WAVE_TABLE[wave_sel][i] : 16'h0000;
            w    = 16'h0000;
            if (!blank) begin
                tgl = tmpl[1:0];
                // A toggle change steps the one-hot pointer; it falls off the top to zero.
                if (tgl != prev_tgl) begin
                    ptr      = (ptr == 8'h00) ? 8'h01 : (ptr << 1);
                    prev_tgl = tgl;
                end
                w = tmpl & keep;
                if (tgl != 2'b00) begin
                    if ((d1 & ptr) == 8'h00) w[BIT_D1] = 1'b1;
                    if ((d2 & ptr) == 8'h00) w[BIT_D2] = 1'b1;
                    if ((d3 & ptr) == 8'h00) w[BIT_D3] = 1'b1;
                end
                if ((w & csync_src) != 16'h0000) begin
                    w[BIT_CSYNC] = 1'b1;
                end
            end
            beat.word        = w;
            beat.last_of_run = (i == RUN_WORDS - 1);
            drive_q.push_back(beat);
        end
        for (int i = TEMPLATE_WORDS; i < RUN_WORDS; i++) begin
            beat.word        = '0;
            beat.last_of_run = (i == RUN_WORDS - 1);
            drive_q.push_back(beat);
        end
    endfunction

    // Compare output beats first, then queue the run of any packet taken on this edge.
    always @(posedge aclk) begin
        drive_beat_t want;
        if (!aresetn) begin
            wave_sel = WAVE_COLOR_A;
            drive_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (drive_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS) begin
                        $display("%0t: unexpected output beat: expected none, got word %h last %b",
                                 $time, m_tdata, m_tlast);
                    end
                end else begin
                    want = drive_q.pop_front();
                    if (m_tdata !== want.word || m_tlast !== want.last_of_run) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS) begin
                            $display("%0t: drive beat: expected word %h last %b, got word %h last %b",
                                     $time, want.word, want.last_of_run, m_tdata, m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expand_packet(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast, s_tuser);
            end
            if (cfg_wr_en) begin
                wave_sel = cfg_wr_data;
            end
        end
        n_pending = drive_q.size();
    end

endmodule

// ----- tb/tb_inkjet_packet_waveform_gen_top.sv -----
module tb_inkjet_packet_waveform_gen_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iwg_pkg::*;

    localparam int N_PHASES        = 8;
    localparam int DIRECTED_PHASES = 4;
    localparam int RANDOM_PER_PHASE = 20;

    localparam logic [SEL_W-1:0] WAVE_PLAN [N_PHASES] = '{
        WAVE_COLOR_A, WAVE_COLOR_B, WAVE_BLACK_A, WAVE_BLACK_B,
        WAVE_BLACK_B, WAVE_COLOR_A, WAVE_BLACK_A, WAVE_COLOR_B};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [SEL_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [WORD_W-1:0]  m_tdata;
    logic               m_tlast;

    int fail_count;
    int words_pending;
    int words_checked;

    int burst_left = 0;
    bit steady_sender = 1'b0;
    int packets_sent = 0;
    int blank_sent = 0;
    int last_sent = 0;
    int stall_cycle = 0;

    inkjet_packet_waveform_gen_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    drive_word_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The receiver cycles through stall patterns: always ready, light, periodic, heavy.
    always @(negedge aclk) begin
        stall_cycle++;
        case ((stall_cycle / 300) % 4)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_tready <= ((stall_cycle % 7) < 4);
            end
            default: begin
                m_tready <= ($urandom_range(0, 1) != 0);
            end
        endcase
    end

    // Drive a packet beat; a spent burst is renewed after a random gap unless steady_sender.
    task automatic send_packet(input logic [7:0] d1, input logic [7:0] d2,
                               input logic [7:0] d3, input logic last_pkt,
                               input logic blank);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {d3, d2, d1};
        s_tlast  <= last_pkt;
        s_tuser  <= blank;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        packets_sent++;
        if (blank) blank_sent++;
        if (last_pkt) last_sent++;
    endtask

    // Stop sending and wait until every expected drive word has come out.
    task automatic drain_outputs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (words_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_waveform(input logic [SEL_W-1:0] sel);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random packet, sometimes with a whole nibble silent so F3 or F5 gets gated.
    task automatic send_random_packet();
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
        int shape;
        d1 = 8'($urandom);
        d2 = 8'($urandom);
        d3 = 8'($urandom);
        shape = $urandom_range(0, 7);
        if (shape == 0) begin
            d1[3:0] = 4'h0; d2[3:0] = 4'h0; d3[3:0] = 4'h0;
        end else if (shape == 1) begin
            d1[7:4] = 4'h0; d2[7:4] = 4'h0; d3[7:4] = 4'h0;
        end else if (shape == 2) begin
            d1 = 8'h00; d2 = 8'h00; d3 = 8'h00;
        end
        send_packet(d1, d2, d3, $urandom_range(0, 13) == 0, $urandom_range(0, 9) == 0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            drain_outputs();
            write_waveform(WAVE_PLAN[p]);
            steady_sender = (p % 2) == 1;

            // Directed corners: silent and full nozzles, one nibble gated, blank lines.
            if (p < DIRECTED_PHASES) begin
                send_packet(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
                send_packet(8'hff, 8'hff, 8'hff, 1'b1, 1'b0);
                send_packet(8'h0f, 8'h00, 8'h00, 1'b0, 1'b0);
                send_packet(8'h00, 8'h00, 8'hf0, 1'b1, 1'b0);
                send_packet(8'h55, 8'haa, 8'h81, 1'b0, 1'b1);
                send_packet(8'hff, 8'hff, 8'hff, 1'b1, 1'b1);
            end

            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                send_random_packet();
            end
        end

        drain_outputs();
        repeat (40) @(posedge aclk);

        $display("Sent %0d packets (%0d blank lines, %0d last packets) across all four waveforms.",
                 packets_sent, blank_sent, last_sent);
        $display("Checked %0d drive words under varying sender gaps and receiver stalls.",
                 words_checked);
        if (fail_count == 0 && words_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
